// ----- design/eba_pkg.sv -----
// ----------------------------------------------------------------------------
// eba_pkg - shared types and constants
// Operation codes, field widths, minifloat fixed-point constants and the
// request item type shared by the execute stage modules.
// ----------------------------------------------------------------------------
package eba_pkg;

   localparam int OpW     = 3;
   localparam int IdxW    = 4;
   localparam int ByteW   = 8;
   localparam int StepsW  = 4;

   // operation codes
   localparam logic [OpW-1:0] OP_OR   = 3'd0;
   localparam logic [OpW-1:0] OP_AND  = 3'd1;
   localparam logic [OpW-1:0] OP_XOR  = 3'd2;
   localparam logic [OpW-1:0] OP_ADD  = 3'd3;
   localparam logic [OpW-1:0] OP_FADD = 3'd4;
   localparam logic [OpW-1:0] OP_ROR  = 3'd5;

   // minifloat layout: sign, 3-bit exponent, 4-bit fraction, hidden one
   localparam int ExpW   = 3;
   localparam int FracW  = 4;
   // unsigned fixed point, 1 integer bit and 11 fraction bits, plus carry
   localparam int FixFracBits = 11;
   localparam int ManW        = FixFracBits + 2;
   localparam int FracShift   = FixFracBits - FracW;
   localparam logic [ManW-1:0] ONE_FIX = ManW'(1) << FixFracBits;

   typedef struct packed {
      logic [OpW-1:0]    operation;
      logic [IdxW-1:0]   dest_index;
      logic [ByteW-1:0]  value_s;
      logic [ByteW-1:0]  value_t;
      logic [StepsW-1:0] rotate_steps;
   } eba_req_type;

endpackage

// ----- design/eba_fadd.sv -----
// ----------------------------------------------------------------------------
// eba_fadd - minifloat adder
// Aligns two 8-bit minifloats, adds or subtracts magnitudes, normalizes one
// step and packs the result; pure combinational logic.
// ----------------------------------------------------------------------------
module eba_fadd (
   input  logic [eba_pkg::ByteW-1:0] a_s,
   input  logic [eba_pkg::ByteW-1:0] a_t,
   output logic [eba_pkg::ByteW-1:0] sum
);
   import eba_pkg::*;

   logic            sgn_s, sgn_t, sgn_r;
   logic [ExpW-1:0] exp_s, exp_t, exp_big, exp_r;
   logic [ExpW-1:0] diff;
   logic [ManW-1:0] man_s, man_t, al_s, al_t, man_sum, man_r, mag;
   logic [FracW-1:0] frac;

   always_comb begin
      sgn_s = a_s[ByteW-1];
      sgn_t = a_t[ByteW-1];
      exp_s = a_s[FracW +: ExpW];
      exp_t = a_t[FracW +: ExpW];
      man_s = ManW'({1'b1, a_s[FracW-1:0]}) << FracShift;
      man_t = ManW'({1'b1, a_t[FracW-1:0]}) << FracShift;

      // align the smaller exponent onto the larger
      if (exp_s > exp_t) begin
         diff    = exp_s - exp_t;
         al_s    = man_s;
         al_t    = man_t >> diff;
         exp_big = exp_s;
      end else begin
         diff    = exp_t - exp_s;
         al_s    = man_s >> diff;
         al_t    = man_t;
         exp_big = exp_t;
      end

      // on equal magnitudes with opposite signs the sign of t wins
      if (sgn_s == sgn_t) begin
         man_sum = al_s + al_t;
         sgn_r   = sgn_s;
      end else if (al_s > al_t) begin
         man_sum = al_s - al_t;
         sgn_r   = sgn_s;
      end else begin
         man_sum = al_t - al_s;
         sgn_r   = sgn_t;
      end

      // single normalize step
      priority if (man_sum[ManW-1]) begin
         man_r = man_sum >> 1;
         exp_r = exp_big + ExpW'(1);
      end else if (!man_sum[ManW-2]) begin
         man_r = man_sum << 1;
         exp_r = exp_big - ExpW'(1);
      end else begin
         man_r = man_sum;
         exp_r = exp_big;
      end

      // fraction is (m - 1) * 16 truncated toward zero, low bits kept
      if (man_r >= ONE_FIX) begin
         mag  = man_r - ONE_FIX;
         frac = mag[FracShift +: FracW];
      end else begin
         mag  = ONE_FIX - man_r;
         frac = FracW'(0) - mag[FracShift +: FracW];
      end

      sum = {sgn_r, exp_r, frac};
   end

endmodule

// ----- design/eba_exec.sv -----
// ----------------------------------------------------------------------------
// eba_exec - operation datapath
// Selects among logic ops, integer add, rotate right and minifloat add for
// one request item.
// ----------------------------------------------------------------------------
module eba_exec (
   input  eba_pkg::eba_req_type      req,
   output logic [eba_pkg::ByteW-1:0] result
);
   import eba_pkg::*;

   logic [ByteW-1:0]   fadd_sum;
   logic [2*ByteW-1:0] rot_dbl;

   eba_fadd u_fadd (
      .a_s (req.value_s),
      .a_t (req.value_t),
      .sum (fadd_sum)
   );

   // rotate the doubled word and keep the low byte
   assign rot_dbl = {req.value_s, req.value_s} >> req.rotate_steps[2:0];

   always_comb begin
      unique case (req.operation)
         OP_OR:   result = req.value_s | req.value_t;
         OP_AND:  result = req.value_s & req.value_t;
         OP_XOR:  result = req.value_s ^ req.value_t;
         OP_ADD:  result = req.value_s + req.value_t;
         OP_FADD: result = fadd_sum;
         OP_ROR:  result = rot_dbl[ByteW-1:0];
         default: result = '0;
      endcase
   end

endmodule

// ----- design/eight_bit_alu_with_minifloat_add.sv -----
// ----------------------------------------------------------------------------
// eight_bit_alu_with_minifloat_add - execute stage
// Registers the operands of one instruction, computes OR/AND/XOR, integer
// add, rotate right or minifloat add, and registers the result byte.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_stall  | operation, dest_index,
//           |           |                      | value_s, value_t, rotate_steps
//   rsp     | out       | rsp_valid/rsp_stall  | write_index, result_value
//
// Order: the operand register loads at the accept edge, then the result register
// loads from it, raising rsp_valid; one item per cycle while rsp_stall is low.
// Reset: synchronous, active high; clears both valid flags, nothing else.
// Stalls: a stalled result holds the result register; the operand register
// still fills if empty, and req_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_minifloat_add (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [eba_pkg::OpW-1:0]    req_operation,
   input  logic [eba_pkg::IdxW-1:0]   req_dest_index,
   input  logic [eba_pkg::ByteW-1:0]  req_value_s,
   input  logic [eba_pkg::ByteW-1:0]  req_value_t,
   input  logic [eba_pkg::StepsW-1:0] req_rotate_steps,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [eba_pkg::IdxW-1:0]   rsp_write_index,
   output logic [eba_pkg::ByteW-1:0]  rsp_result_value
);
   import eba_pkg::*;

   // operand stage
   logic        s1_valid_ff, s1_valid_in;
   eba_req_type s1_item_ff, s1_item_in;
   // result stage
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IdxW-1:0]  rsp_index_ff, rsp_index_in;
   logic [ByteW-1:0] rsp_value_ff, rsp_value_in;

   logic             s2_advance;  // operand stage moves into result stage
   logic             s1_take;     // operand stage can load a new item
   logic [ByteW-1:0] exec_result;

   eba_exec u_exec (
      .req    (s1_item_ff),
      .result (exec_result)
   );

   // advance when the result register is empty or being drained this cycle
   assign s2_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_take    = !s1_valid_ff || s2_advance;
   assign req_stall  = !s1_take;

   always_comb begin
      // operand stage: load on accept, otherwise hold or drop
      s1_item_in  = s1_item_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_take) begin
         s1_valid_in = req_valid;
         s1_item_in  = '{operation:    req_operation,
                         dest_index:   req_dest_index,
                         value_s:      req_value_s,
                         value_t:      req_value_t,
                         rotate_steps: req_rotate_steps};
      end

      // result stage: capture the executed item, hold while stalled
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      if (s2_advance) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = s1_item_ff.dest_index;
         rsp_value_in = exec_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_index  = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;

   // input side only stalls with a full operand stage
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall raised with empty operand stage");

   // an advancing item shows up as a result next cycle
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      s2_advance |=> rsp_valid && rsp_write_index == $past(s1_item_ff.dest_index))
      else $error("advanced item missing from result register");

   // a result that is stalled is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !s2_advance)
      else $error("stalled result would be overwritten");

   // reset empties both stages
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

// ----- bench/eight_bit_alu_with_minifloat_add_tb.sv -----
// ----------------------------------------------------------------------------
// eight_bit_alu_with_minifloat_add_tb - execute stage testbench
// Drives instruction items through the request channel and checks every
// result item against a typed-in byte or a model of the ALU and minifloat
// adder. A short directed table covers operand extremes, every operation
// code, the minifloat corner cases and the unused codes. Random items
// follow, with random idling on both channels, a long receiver hold-off
// that fills the pipeline, a full drain pause and a stretch with no idling.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_minifloat_add_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import eba_pkg::*;

   // codes the block must still answer, with a zero result byte
   localparam logic [OpW-1:0] OP_UNUSED6 = 3'd6;
   localparam logic [OpW-1:0] OP_UNUSED7 = 3'd7;

   localparam int IdlePercent = 28;
   localparam int HoldCycles  = 60;
   localparam int SettleCycles = 4;
   localparam int DirRows     = 23;

   typedef struct packed {
      logic [IdxW-1:0]  write_index;
      logic [ByteW-1:0] result_value;
   } alu_result_type;

   // one directed row: the item, plus a typed-in result where it is obvious
   typedef struct packed {
      logic [OpW-1:0]    operation;
      logic [IdxW-1:0]   dest_index;
      logic [ByteW-1:0]  value_s;
      logic [ByteW-1:0]  value_t;
      logic [StepsW-1:0] rotate_steps;
      logic              typed;
      logic [ByteW-1:0]  want;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OpW-1:0]      req_operation = '0;
   logic [IdxW-1:0]     req_dest_index = '0;
   logic [ByteW-1:0]    req_value_s = '0;
   logic [ByteW-1:0]    req_value_t = '0;
   logic [StepsW-1:0]   req_rotate_steps = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [IdxW-1:0]     rsp_write_index;
   logic [ByteW-1:0]    rsp_result_value;

   alu_result_type pending_results[$];
   int          error_count = 0;
   int          items_sent = 0;
   int          results_checked = 0;
   int          op_seen [8] = '{default: 0};
   logic        no_idle = 1'b0;
   int          hold_request = 0;

   dir_row_type dir_rows [DirRows] = '{
      // bitwise extremes
      '{OP_OR,      4'd0,  8'h00, 8'h00, 4'd0,  1'b1, 8'h00},
      '{OP_OR,      4'd15, 8'hFF, 8'h00, 4'd0,  1'b1, 8'hFF},
      '{OP_AND,     4'd1,  8'hFF, 8'hFF, 4'd15, 1'b1, 8'hFF},
      '{OP_AND,     4'd14, 8'hAA, 8'h55, 4'd0,  1'b1, 8'h00},
      '{OP_XOR,     4'd2,  8'hFF, 8'hFF, 4'd0,  1'b1, 8'h00},
      '{OP_XOR,     4'd13, 8'hA5, 8'h0F, 4'd0,  1'b1, 8'hAA},
      // integer add wraps mod 256
      '{OP_ADD,     4'd3,  8'hFF, 8'h01, 4'd0,  1'b1, 8'h00},
      '{OP_ADD,     4'd12, 8'hFF, 8'hFF, 4'd0,  1'b1, 8'hFE},
      '{OP_ADD,     4'd4,  8'h7F, 8'h01, 4'd0,  1'b1, 8'h80},
      // rotate: zero count, count of one, count taken mod 8
      '{OP_ROR,     4'd5,  8'h81, 8'hFF, 4'd0,  1'b1, 8'h81},
      '{OP_ROR,     4'd11, 8'h01, 8'h00, 4'd1,  1'b1, 8'h80},
      '{OP_ROR,     4'd6,  8'h01, 8'hFF, 4'd8,  1'b1, 8'h01},
      '{OP_ROR,     4'd10, 8'h80, 8'h00, 4'd15, 1'b1, 8'h01},
      // minifloat: zero operands, exponent wrap, widest alignment
      '{OP_FADD,    4'd7,  8'h00, 8'h00, 4'd0,  1'b0, 8'h00},
      '{OP_FADD,    4'd9,  8'h7F, 8'h7F, 4'd0,  1'b0, 8'h00},
      '{OP_FADD,    4'd8,  8'h70, 8'h0F, 4'd0,  1'b0, 8'h00},
      '{OP_FADD,    4'd0,  8'hFF, 8'h80, 4'd0,  1'b0, 8'h00},
      // equal magnitudes, opposite signs: sign follows value_t
      '{OP_FADD,    4'd15, 8'h35, 8'hB5, 4'd0,  1'b0, 8'h00},
      '{OP_FADD,    4'd1,  8'hB5, 8'h35, 4'd0,  1'b0, 8'h00},
      // still below one after the single normalize step
      '{OP_FADD,    4'd2,  8'h18, 8'h97, 4'd0,  1'b0, 8'h00},
      '{OP_FADD,    4'd3,  8'hA1, 8'h30, 4'd0,  1'b0, 8'h00},
      // unused codes give zero
      '{OP_UNUSED6, 4'd4,  8'hFF, 8'hFF, 4'd15, 1'b1, 8'h00},
      '{OP_UNUSED7, 4'd15, 8'hFF, 8'hFF, 4'd15, 1'b1, 8'h00}
   };

   eight_bit_alu_with_minifloat_add i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_dest_index   (req_dest_index),
      .req_value_s      (req_value_s),
      .req_value_t      (req_value_t),
      .req_rotate_steps (req_rotate_steps),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_index  (rsp_write_index),
      .rsp_result_value (rsp_result_value)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Add two minifloats in Q1.11: align, add or subtract magnitudes,
   // normalize one step, then truncate the fraction toward zero.
   function automatic logic [ByteW-1:0] minifloat_add(input logic [ByteW-1:0] a,
                                                      input logic [ByteW-1:0] b);
      logic [ManW-1:0]  man_a;
      logic [ManW-1:0]  man_b;
      logic [ManW-1:0]  man_sum;
      logic [ManW-1:0]  shortfall;
      logic [ExpW-1:0]  exp_a;
      logic [ExpW-1:0]  exp_b;
      logic [ExpW-1:0]  exp_sum;
      logic             sgn_sum;
      logic [FracW-1:0] frac;
      man_a = ManW'({1'b1, a[3:0]}) << FracShift;
      man_b = ManW'({1'b1, b[3:0]}) << FracShift;
      exp_a = a[6:4];
      exp_b = b[6:4];
      // shift the smaller operand; at most 7 places, so nothing is lost
      if (exp_a > exp_b) begin
         man_b = man_b >> (exp_a - exp_b);
         exp_sum = exp_a;
      end else begin
         man_a = man_a >> (exp_b - exp_a);
         exp_sum = exp_b;
      end
      if (a[7] == b[7]) begin
         man_sum = man_a + man_b;
         sgn_sum = a[7];
      end else if (man_a > man_b) begin
         man_sum = man_a - man_b;
         sgn_sum = a[7];
      end else begin
         // ties land here, so an exact cancel takes the sign of b
         man_sum = man_b - man_a;
         sgn_sum = b[7];
      end
      // one normalize step only; the exponent wraps in its 3 bits
      if (man_sum >= (ONE_FIX << 1)) begin
         man_sum = man_sum >> 1;
         exp_sum = exp_sum + 1'b1;
      end else if (man_sum < ONE_FIX) begin
         man_sum = man_sum << 1;
         exp_sum = exp_sum - 1'b1;
      end
      if (man_sum >= ONE_FIX) begin
         frac = FracW'((man_sum - ONE_FIX) >> FracShift);
      end else begin
         // below one: negate the truncated shortfall, keep the low bits
         shortfall = (ONE_FIX - man_sum) >> FracShift;
         frac = 4'd0 - shortfall[FracW-1:0];
      end
      return {sgn_sum, exp_sum, frac};
   endfunction

   function automatic alu_result_type execute_op(input eba_req_type it);
      alu_result_type     res;
      logic [2*ByteW-1:0] doubled;
      res.write_index = it.dest_index;
      case (it.operation)
         OP_OR:   res.result_value = it.value_s | it.value_t;
         OP_AND:  res.result_value = it.value_s & it.value_t;
         OP_XOR:  res.result_value = it.value_s ^ it.value_t;
         OP_ADD:  res.result_value = it.value_s + it.value_t;
         OP_FADD: res.result_value = minifloat_add(it.value_s, it.value_t);
         OP_ROR: begin
            // rotate through a doubled copy; count is mod 8
            doubled = {it.value_s, it.value_s} >> it.rotate_steps[2:0];
            res.result_value = doubled[ByteW-1:0];
         end
         default: res.result_value = '0;
      endcase
      return res;
   endfunction

   // Bias operands toward the byte extremes now and then.
   function automatic logic [ByteW-1:0] pick_operand();
      case ($urandom_range(15))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return ByteW'($urandom);
      endcase
   endfunction

   // Offer one item, idling first at random; hold it until accepted,
   // then log what the block must return for it.
   task automatic send_item(input eba_req_type it, input logic typed,
                            input logic [ByteW-1:0] want);
      alu_result_type res;
      while (!no_idle && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= it.operation;
      req_dest_index   <= it.dest_index;
      req_value_s      <= it.value_s;
      req_value_t      <= it.value_t;
      req_rotate_steps <= it.rotate_steps;
      do @(posedge clock); while (req_stall);
      res = execute_op(it);
      if (typed) begin
         res.result_value = want;
      end
      pending_results.push_back(res);
      items_sent++;
      op_seen[it.operation]++;
   endtask

   task automatic send_random(input int count);
      eba_req_type it;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            it.operation = OP_UNUSED6;
         end else if (pick < 4) begin
            it.operation = OP_UNUSED7;
         end else begin
            it.operation = OpW'($urandom_range(5));
         end
         it.dest_index   = IdxW'($urandom);
         it.value_s      = pick_operand();
         it.value_t      = pick_operand();
         it.rotate_steps = StepsW'($urandom);
         // steer float adds toward cancellation and shared exponents
         if (it.operation == OP_FADD) begin
            case ($urandom_range(3))
               0: it.value_t = it.value_s ^ 8'h80;
               1: it.value_t = {1'($urandom), it.value_s[6:4], 4'($urandom)};
               default: ;
            endcase
         end
         send_item(it, 1'b0, '0);
      end
   endtask

   // Drop valid and wait until every logged result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Receiver: check each accepted result against the oldest logged one,
   // then choose the stall for the next cycle. A bump of hold_request
   // starts a long hold-off counted here.
   int hold_seen = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      alu_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with no item pending: index %0d value %02h",
                        $time, rsp_write_index, rsp_result_value);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (rsp_write_index !== want.write_index) begin
                  $display("%0t: write_index expected %0d actual %0d",
                           $time, want.write_index, rsp_write_index);
                  error_count++;
               end
               if (rsp_result_value !== want.result_value) begin
                  $display("%0t: result_value expected %02h actual %02h",
                           $time, want.result_value, rsp_result_value);
                  error_count++;
               end
            end
         end
         if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < IdlePercent);
         end
      end
   end

   // Main sequence: reset, directed table, then random phases.
   initial begin
      eba_req_type it;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (dir_rows[i]) begin
         it.operation    = dir_rows[i].operation;
         it.dest_index   = dir_rows[i].dest_index;
         it.value_s      = dir_rows[i].value_s;
         it.value_t      = dir_rows[i].value_t;
         it.rotate_steps = dir_rows[i].rotate_steps;
         send_item(it, dir_rows[i].typed, dir_rows[i].want);
      end

      // random items with idling on both sides
      send_random(500);

      // pause the sender until the pipeline is empty
      wait_for_results();

      // hold off the receiver while the sender streams: fill the block
      // until it stalls the request side, then keep going without idling
      no_idle = 1'b1;
      hold_request++;
      send_random(250);
      no_idle = 1'b0;

      send_random(700);

      wait_for_results();
      repeat (SettleCycles) @(posedge clock);

      $display("Sent %0d items (%0d directed), checked %0d results; per code: %p",
               items_sent, DirRows, results_checked, op_seen);
      $display("Covered random idle and stall, a %0d-cycle receiver hold, and a drain pause",
               HoldCycles);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("[eight_bit_alu_with_minifloat_add] OK");
      end else begin
         $display("[eight_bit_alu_with_minifloat_add] ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("[eight_bit_alu_with_minifloat_add] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
design/eba_pkg.sv
design/eba_fadd.sv
design/eba_exec.sv
design/eight_bit_alu_with_minifloat_add.sv
bench/eight_bit_alu_with_minifloat_add_tb.sv
